/* design/lst_pkg.sv */
`default_nettype none
package lst_pkg;

	localparam int unsigned CYC_W      = 8;
	localparam int unsigned LINE_W     = 8;
	localparam int unsigned TICK_W     = 10;
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 8;

	typedef enum logic [1:0] {
		MODE_HORZ_BLANK = 2'd0,
		MODE_VERT_BLANK = 2'd1,
		MODE_SEARCH     = 2'd2,
		MODE_TRANSFER   = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COMPARE_LINE     = 4'd0,
		REG_COINCIDENCE_EN   = 4'd1,
		REG_COINCIDENCE_EQ   = 4'd2,
		REG_HBLANK_IRQ_EN    = 4'd3,
		REG_VBLANK_IRQ_EN    = 4'd4,
		REG_SEARCH_IRQ_EN    = 4'd5,
		REG_BACKGROUND_EN    = 4'd6,
		REG_SPRITE_EN        = 4'd7
	} cfg_reg_t;

	localparam logic [TICK_W-1:0] TICKS_HBLANK   = 10'd204;
	localparam logic [TICK_W-1:0] TICKS_VBLANK   = 10'd456;
	localparam logic [TICK_W-1:0] TICKS_SEARCH   = 10'd80;
	localparam logic [TICK_W-1:0] TICKS_TRANSFER = 10'd172;
	localparam logic [TICK_W-1:0] TICKS_MAX      = 10'd710;

	localparam logic [LINE_W-1:0] LINE_VBLANK_START = 8'd144;
	localparam logic [LINE_W-1:0] LINE_LAST         = 8'd153;

	typedef struct packed {
		logic [LINE_W-1:0] compare_line;
		logic              coincidence_irq_enable;
		logic              coincidence_on_equal;
		logic              hblank_irq_enable;
		logic              vblank_irq_enable;
		logic              search_irq_enable;
		logic              background_enable;
		logic              sprite_enable;
	} cfg_t;

	typedef struct packed {
		mode_t             mode;
		logic [LINE_W-1:0] line;
		logic [TICK_W-1:0] ticks;
	} state_t;

	typedef struct packed {
		mode_t             mode;
		logic [LINE_W-1:0] line;
		logic              vblank_irq;
		logic              status_irq;
		logic              draw_background;
		logic              draw_sprites;
		logic              frame_done;
	} result_t;

endpackage
`default_nettype wire

/* design/lst_cfg_regs.sv */
`default_nettype none
module lst_cfg_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [lst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lst_pkg::CFG_DATA_W-1:0] cfg_data,
	output lst_pkg::cfg_t                     cfg
);

	lst_pkg::cfg_t cfg_q;

	// keep only the low bits of each register's width; drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (lst_pkg::cfg_reg_t'(cfg_index))
				lst_pkg::REG_COMPARE_LINE:   cfg_q.compare_line <= cfg_data;
				lst_pkg::REG_COINCIDENCE_EN: cfg_q.coincidence_irq_enable <= cfg_data[0];
				lst_pkg::REG_COINCIDENCE_EQ: cfg_q.coincidence_on_equal <= cfg_data[0];
				lst_pkg::REG_HBLANK_IRQ_EN:  cfg_q.hblank_irq_enable <= cfg_data[0];
				lst_pkg::REG_VBLANK_IRQ_EN:  cfg_q.vblank_irq_enable <= cfg_data[0];
				lst_pkg::REG_SEARCH_IRQ_EN:  cfg_q.search_irq_enable <= cfg_data[0];
				lst_pkg::REG_BACKGROUND_EN:  cfg_q.background_enable <= cfg_data[0];
				lst_pkg::REG_SPRITE_EN:      cfg_q.sprite_enable <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* design/lst_step.sv */
`default_nettype none
module lst_step (
	input  wire lst_pkg::cfg_t             cfg,
	input  wire lst_pkg::state_t           cur,
	input  wire logic [lst_pkg::CYC_W-1:0] elapsed_cycles,
	output lst_pkg::state_t                nxt,
	output lst_pkg::result_t               res
);

	logic [lst_pkg::TICK_W-1:0] sum;
	logic [lst_pkg::LINE_W-1:0] line_inc;
	logic                       changed;
	logic                       frame;
	logic                       drew;
	logic                       equal;
	logic                       coin_hit;

	assign sum      = cur.ticks + {{(lst_pkg::TICK_W-lst_pkg::CYC_W){1'b0}}, elapsed_cycles};
	assign line_inc = cur.line + 8'd1;

	// at most one transition per item; a transition drops the excess ticks
	always_comb begin
		nxt       = cur;
		nxt.ticks = sum;
		changed   = 1'b0;
		frame     = 1'b0;
		drew      = 1'b0;
		unique case (cur.mode)
			lst_pkg::MODE_HORZ_BLANK: begin
				if (sum >= lst_pkg::TICKS_HBLANK) begin
					nxt.ticks = '0;
					nxt.line  = line_inc;
					changed   = 1'b1;
					if (line_inc == lst_pkg::LINE_VBLANK_START) begin
						nxt.mode = lst_pkg::MODE_VERT_BLANK;
						frame    = 1'b1;
					end else begin
						nxt.mode = lst_pkg::MODE_SEARCH;
					end
				end
			end
			lst_pkg::MODE_VERT_BLANK: begin
				if (sum >= lst_pkg::TICKS_VBLANK) begin
					nxt.ticks = '0;
					nxt.line  = line_inc;
					if (line_inc > lst_pkg::LINE_LAST) begin
						nxt.line = '0;
						nxt.mode = lst_pkg::MODE_SEARCH;
						changed  = 1'b1;
					end
				end
			end
			lst_pkg::MODE_SEARCH: begin
				if (sum >= lst_pkg::TICKS_SEARCH) begin
					nxt.ticks = '0;
					nxt.mode  = lst_pkg::MODE_TRANSFER;
					changed   = 1'b1;
				end
			end
			default: begin
				if (sum >= lst_pkg::TICKS_TRANSFER) begin
					nxt.ticks = '0;
					nxt.mode  = lst_pkg::MODE_HORZ_BLANK;
					changed   = 1'b1;
					drew      = 1'b1;
				end
			end
		endcase
	end

	assign equal    = (nxt.line == cfg.compare_line);
	assign coin_hit = cfg.coincidence_on_equal ? equal : !equal;

	always_comb begin
		res.mode            = nxt.mode;
		res.line            = nxt.line;
		res.vblank_irq      = (nxt.line == lst_pkg::LINE_VBLANK_START);
		res.status_irq      = (cfg.coincidence_irq_enable && coin_hit)
			|| (cfg.hblank_irq_enable && changed && nxt.mode == lst_pkg::MODE_HORZ_BLANK)
			|| (cfg.vblank_irq_enable && changed && nxt.mode == lst_pkg::MODE_VERT_BLANK)
			|| (cfg.search_irq_enable && changed && nxt.mode == lst_pkg::MODE_SEARCH);
		res.draw_background = drew && cfg.background_enable;
		res.draw_sprites    = drew && cfg.sprite_enable;
		res.frame_done      = frame;
	end

endmodule
`default_nettype wire

/* design/lcd_scanline_mode_timer.sv */
// Path: an accepted input item passes through the input register, then the
// result register, before its result item is presented.
// Throughput: one item per cycle while result_stall is low; the mode, line and
// tick registers close a loop of one 10-bit add and compare per item.
// Reset: arst_n clears mode (hblank), line, ticks, all configuration and both
// valid flags asynchronously; payload registers are not reset.
`default_nettype none
module lcd_scanline_mode_timer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration write port
	input  wire logic                           cfg_we,
	input  wire logic [lst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lst_pkg::CFG_DATA_W-1:0] cfg_data,
	// input item channel
	input  wire logic                           item_valid,
	output logic                                item_stall,
	input  wire logic [lst_pkg::CYC_W-1:0]      elapsed_cycles,
	// result item channel
	output logic                                result_valid,
	input  wire logic                           result_stall,
	output logic [1:0]                          mode,
	output logic [lst_pkg::LINE_W-1:0]          line,
	output logic                                vblank_irq,
	output logic                                status_irq,
	output logic                                draw_background,
	output logic                                draw_sprites,
	output logic                                frame_done
);

	lst_pkg::cfg_t    cfg;
	lst_pkg::state_t  state_q;
	lst_pkg::state_t  state_nxt;
	lst_pkg::result_t res_nxt;
	lst_pkg::result_t res_q;

	logic                      valid_s1;
	logic [lst_pkg::CYC_W-1:0] elapsed_s1;
	logic                      out_valid_q;
	logic                      advance;
	logic                      in_take;

	lst_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lst_step u_step (
		.cfg            (cfg),
		.cur            (state_q),
		.elapsed_cycles (elapsed_s1),
		.nxt            (state_nxt),
		.res            (res_nxt)
	);

	// The result register frees up when empty or when its item is taken this
	// cycle; the input stage moves on then, so a new item can enter every cycle while the result side does not stall.
	assign advance    = !out_valid_q || !result_stall;
	assign item_stall = valid_s1 && !advance;
	assign in_take    = item_valid && !item_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			elapsed_s1 <= elapsed_cycles;
		end
	end

	// timing state: advance only when the item in the input stage moves out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode  <= lst_pkg::MODE_HORZ_BLANK;
			state_q.line  <= '0;
			state_q.ticks <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_q <= res_nxt;
		end
	end

	assign result_valid    = out_valid_q;
	assign mode            = res_q.mode;
	assign line            = res_q.line;
	assign vblank_irq      = res_q.vblank_irq;
	assign status_irq      = res_q.status_irq;
	assign draw_background = res_q.draw_background;
	assign draw_sprites    = res_q.draw_sprites;
	assign frame_done      = res_q.frame_done;

	// tick counter never reaches the point where it could wrap
	a_ticks_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.ticks <= lst_pkg::TICKS_MAX)
		else $error("mode tick counter out of range");

	// vblank mode only covers the vblank lines
	a_vblank_lines: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == lst_pkg::MODE_VERT_BLANK |->
		(state_q.line >= lst_pkg::LINE_VBLANK_START && state_q.line <= lst_pkg::LINE_LAST))
		else $error("vblank mode outside vblank lines");

	// frame completion comes with the move into vblank at the first vblank line
	a_frame_done: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && frame_done) |->
		(mode == lst_pkg::MODE_VERT_BLANK && line == lst_pkg::LINE_VBLANK_START && vblank_irq))
		else $error("frame_done without entry into vblank");

	// a line draw strobe only comes with the move into hblank
	a_draw_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (draw_background || draw_sprites)) |->
		mode == lst_pkg::MODE_HORZ_BLANK)
		else $error("draw strobe outside hblank entry");

	// stall only while an item sits in the input stage behind a full result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && out_valid_q && result_stall))
		else $error("input stalled without a blocked item");

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
	import lst_pkg::*;

	localparam int unsigned ITEMS_PER_PHASE = 325;
	localparam int unsigned NUM_PHASES      = 6;
	localparam int unsigned IDLE_LIMIT      = 2000;
	// two-stage pipeline; leave a few spare cycles to catch stray results
	localparam int unsigned DRAIN_CYCLES    = 8;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 4'd8;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = 4'd15;

	// Scoreboard: tracks mode, line and tick count alongside the block and
	// keeps the results still owed by it, oldest first.
	class scanline_scoreboard;
		cfg_t              regs;
		mode_t             cur_mode;
		logic [LINE_W-1:0] cur_line;
		logic [TICK_W-1:0] ticks;
		result_t           due_results[$];
		int unsigned       n_items, n_results, n_errors;
		int unsigned       n_frames, n_status, n_draws;

		function new();
			regs     = '0;
			cur_mode = MODE_HORZ_BLANK;
			cur_line = '0;
			ticks    = '0;
		endfunction

		// keep only the low bits of each register; unused indexes drop out
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_COMPARE_LINE:   regs.compare_line           = data;
				REG_COINCIDENCE_EN: regs.coincidence_irq_enable = data[0];
				REG_COINCIDENCE_EQ: regs.coincidence_on_equal   = data[0];
				REG_HBLANK_IRQ_EN:  regs.hblank_irq_enable      = data[0];
				REG_VBLANK_IRQ_EN:  regs.vblank_irq_enable      = data[0];
				REG_SEARCH_IRQ_EN:  regs.search_irq_enable      = data[0];
				REG_BACKGROUND_EN:  regs.background_enable      = data[0];
				REG_SPRITE_EN:      regs.sprite_enable          = data[0];
				default: ;
			endcase
		endfunction

		function result_t step_timer(logic [CYC_W-1:0] cyc);
			result_t r;
			logic    changed, frame, drew, hit;
			changed = 1'b0;
			frame   = 1'b0;
			drew    = 1'b0;
			ticks   = ticks + TICK_W'(cyc);
			case (cur_mode)
				MODE_HORZ_BLANK: if (ticks >= TICKS_HBLANK) begin
					ticks    = '0;
					cur_line = cur_line + 8'd1;
					if (cur_line == LINE_VBLANK_START) begin
						cur_mode = MODE_VERT_BLANK;
						frame    = 1'b1;
					end else begin
						cur_mode = MODE_SEARCH;
					end
					changed = 1'b1;
				end
				MODE_VERT_BLANK: if (ticks >= TICKS_VBLANK) begin
					// each vblank line advances; only the wrap is a mode change
					ticks    = '0;
					cur_line = cur_line + 8'd1;
					if (cur_line > LINE_LAST) begin
						cur_line = '0;
						cur_mode = MODE_SEARCH;
						changed  = 1'b1;
					end
				end
				MODE_SEARCH: if (ticks >= TICKS_SEARCH) begin
					ticks    = '0;
					cur_mode = MODE_TRANSFER;
					changed  = 1'b1;
				end
				default: if (ticks >= TICKS_TRANSFER) begin
					ticks    = '0;
					cur_mode = MODE_HORZ_BLANK;
					changed  = 1'b1;
					drew     = 1'b1;
				end
			endcase
			hit = (cur_line == regs.compare_line);
			r.mode            = cur_mode;
			r.line            = cur_line;
			r.vblank_irq      = (cur_line == LINE_VBLANK_START);
			r.status_irq      = (regs.coincidence_irq_enable &&
				(regs.coincidence_on_equal ? hit : !hit)) ||
				(changed && regs.hblank_irq_enable && cur_mode == MODE_HORZ_BLANK) ||
				(changed && regs.vblank_irq_enable && cur_mode == MODE_VERT_BLANK) ||
				(changed && regs.search_irq_enable && cur_mode == MODE_SEARCH);
			r.draw_background = drew && regs.background_enable;
			r.draw_sprites    = drew && regs.sprite_enable;
			r.frame_done      = frame;
			return r;
		endfunction

		function void note_item(logic [CYC_W-1:0] cyc);
			due_results.push_back(step_timer(cyc));
			n_items++;
		endfunction

		function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
				n_errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				$display("%0t: result item with none outstanding (mode %0d, line %0d)",
					$time, got.mode, got.line);
				n_errors++;
				return;
			end
			want = due_results.pop_front();
			n_results++;
			n_frames += want.frame_done;
			n_status += want.status_irq;
			n_draws  += want.draw_background | want.draw_sprites;
			cmp_field("mode",            8'(want.mode),            8'(got.mode));
			cmp_field("line",            want.line,                got.line);
			cmp_field("vblank_irq",      8'(want.vblank_irq),      8'(got.vblank_irq));
			cmp_field("status_irq",      8'(want.status_irq),      8'(got.status_irq));
			cmp_field("draw_background", 8'(want.draw_background), 8'(got.draw_background));
			cmp_field("draw_sprites",    8'(want.draw_sprites),    8'(got.draw_sprites));
			cmp_field("frame_done",      8'(want.frame_done),      8'(got.frame_done));
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  item_valid;
	logic                  item_stall;
	logic [CYC_W-1:0]      elapsed_cycles;
	logic                  result_valid;
	logic                  result_stall;
	logic [1:0]            mode;
	logic [LINE_W-1:0]     line;
	logic                  vblank_irq;
	logic                  status_irq;
	logic                  draw_background;
	logic                  draw_sprites;
	logic                  frame_done;

	scanline_scoreboard    sb = new();
	logic [CFG_DATA_W-1:0] reg_vals [8];
	bit                    tx_quiet, rx_quiet;
	int unsigned           n_settings;

	// Hand-picked opening items: zero, the top value, alternating bit
	// patterns, and counts that land exactly on the search, transfer and
	// hblank thresholds.
	logic [CYC_W-1:0] directed_cycles [$] = '{8'd0, 8'd203, 8'd1, 8'd79, 8'd1, 8'd171,
		8'd1, 8'd255, 8'h55, 8'hAA, 8'd2, 8'd128, 8'd76, 8'd255, 8'd255, 8'd255,
		8'd203, 8'd0, 8'd1};

	lcd_scanline_mode_timer uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned draw_gap(bit quiet);
		return quiet ? 0 : $urandom_range(0, 15);
	endfunction

	// Lean toward large counts so the line walks into vblank several times;
	// keep some small and full-range counts for the threshold edges.
	function automatic logic [CYC_W-1:0] draw_cycles();
		case ($urandom_range(0, 9))
			0:       return CYC_W'($urandom_range(0, 15));
			1, 2:    return CYC_W'($urandom_range(0, 255));
			default: return CYC_W'($urandom_range(200, 255));
		endcase
	endfunction

	// Present one item after a random gap; hold it until accepted.
	task automatic send_item(input logic [CYC_W-1:0] cyc);
		int unsigned gap;
		if (sb.n_items % 64 == 0) tx_quiet = ($urandom_range(0, 2) == 0);
		gap = draw_gap(tx_quiet);
		@(negedge clk);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid     <= 1'b1;
		elapsed_cycles <= cyc;
		do @(posedge clk); while (item_stall !== 1'b0);
		sb.note_item(cyc);
	endtask

	task automatic drop_input();
		@(negedge clk);
		item_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.due_results.size() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.write_reg(idx, data);
	endtask

	// Write every register from reg_vals, then poke an unused index that the
	// block must ignore.
	task automatic apply_settings();
		for (int i = REG_COMPARE_LINE; i <= REG_SPRITE_EN; i++) begin
			cfg_write(CFG_IDX_W'(i), reg_vals[i]);
		end
		cfg_write(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
			CFG_DATA_W'($urandom_range(0, 255)));
		@(negedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// Result side: stall for a random count, then take the next item.
	initial begin
		int unsigned hold, n_taken;
		result_stall = 1'b0;
		n_taken      = 0;
		forever begin
			if (n_taken % 64 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
			hold = draw_gap(rx_quiet);
			@(negedge clk);
			if (hold != 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (result_valid !== 1'b1);
			n_taken++;
		end
	end

	// Check every accepted result against the oldest prediction.
	always @(posedge clk) begin
		result_t got;
		if (result_valid && !result_stall) begin
			got.mode            = mode_t'(mode);
			got.line            = line;
			got.vblank_irq      = vblank_irq;
			got.status_irq      = status_irq;
			got.draw_background = draw_background;
			got.draw_sprites    = draw_sprites;
			got.frame_done      = frame_done;
			sb.check_result(got);
		end
	end

	// Watchdog: end the run if no handshake happens for too long.
	initial begin
		int unsigned idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) idle = 0;
			else idle++;
		end
		$display("Timeout: %0d cycles without a handshake at %0t", IDLE_LIMIT, $time);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		item_valid     = 1'b0;
		elapsed_cycles = '0;
		n_settings     = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// Opening settings: watch line 3 for equality, enable the hblank and
		// search sources and both draw strobes. High data bits must be
		// dropped, so vblank enable reads as off from 8'hFE.
		reg_vals = '{8'd3, 8'hFF, 8'h01, 8'hFF, 8'hFE, 8'h81, 8'hFF, 8'hFF};
		apply_settings();
		foreach (directed_cycles[i]) send_item(directed_cycles[i]);
		drop_input();
		wait_drained();

		for (int k = 0; k < NUM_PHASES; k++) begin
			// Extremes first: all off, then all on with an unreachable compare
			// line, then vblank start as compare, then fire-on-differ at line 0.
			case (k)
				0: foreach (reg_vals[i]) reg_vals[i] = '0;
				1: foreach (reg_vals[i]) reg_vals[i] = '1;
				default: begin
					foreach (reg_vals[i]) reg_vals[i] = CFG_DATA_W'($urandom_range(0, 255));
					reg_vals[REG_COMPARE_LINE] = CFG_DATA_W'($urandom_range(0, LINE_LAST));
				end
			endcase
			if (k == 2) reg_vals[REG_COMPARE_LINE] = LINE_VBLANK_START;
			if (k == 3) begin
				reg_vals[REG_COMPARE_LINE]   = '0;
				reg_vals[REG_COINCIDENCE_EN] = 8'h01;
				reg_vals[REG_COINCIDENCE_EQ] = 8'hFE;
			end
			apply_settings();
			repeat (ITEMS_PER_PHASE) send_item(draw_cycles());
			drop_input();
			wait_drained();
		end

		// hold for stray results past the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d items under %0d register settings, %0d results checked;",
			sb.n_items, n_settings, sb.n_results);
		$display("  saw %0d frame ends, %0d status interrupts, %0d line draws.",
			sb.n_frames, sb.n_status, sb.n_draws);
		if (sb.n_errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* files.f */
design/lst_pkg.sv
design/lst_cfg_regs.sv
design/lst_step.sv
design/lcd_scanline_mode_timer.sv
tb/tb_top.sv
